// File: hw/rtl/plf_pkg.sv
package plf_pkg;

  // Field and register widths.
  localparam int GainW   = 18;
  localparam int DistW   = 25;
  localparam int PosW    = 32;
  localparam int SumW    = 40;
  localparam int AngW    = 16;
  localparam int SampW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 32;

  // Fixed-point layout of the rotator.
  localparam int VecW  = 34;   // Q1.30 vector with headroom
  localparam int ZW    = 28;   // Q.24 residual angle
  localparam int IterW = 5;    // holds any iteration index up to 23

  localparam int CORDIC_ITERATIONS_DEF = 16;

  localparam logic signed [VecW-1:0] CordicK = VecW'(652032874);
  localparam logic signed [AngW-1:0] HalfPiQ14 = AngW'(25736);

  // Register reset values.
  localparam logic [GainW-1:0] GainPRst = GainW'(19661);
  localparam logic [GainW-1:0] GainDRst = GainW'(6554);
  localparam logic [GainW-1:0] GainIRst = GainW'(66);
  localparam logic [DistW-1:0] StepDistRst = DistW'(65536);
  localparam logic [DistW-1:0] SigmaRst = DistW'(131072);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_D   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_STEP     = 3'd3,
    REG_SIGMA    = 3'd4,
    REG_START_X  = 3'd5,
    REG_START_Y  = 3'd6
  } reg_idx_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RESTART,
    CMD_NOISE,
    CMD_MEAS,
    CMD_SUMP,
    CMD_MULD,
    CMD_MULI,
    CMD_STEER,
    CMD_CINIT,
    CMD_ROT,
    CMD_MOVEX,
    CMD_MOVEY,
    CMD_FIN,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IterW-1:0] iter;
  } dp_ctrl_t;

  // Arctangent table in Q.24, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [IterW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = ZW'(13176795);
      5'd1:    r = ZW'(7778716);
      5'd2:    r = ZW'(4110060);
      5'd3:    r = ZW'(2086331);
      5'd4:    r = ZW'(1047214);
      5'd5:    r = ZW'(524117);
      5'd6:    r = ZW'(262123);
      5'd7:    r = ZW'(131069);
      default: r = ZW'(28'sd1 <<< (5'd24 - i));
    endcase
    return r;
  endfunction

  // Saturate a 33-bit sum to the 32-bit signed range.
  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW:0] v);
    logic signed [PosW-1:0] r;
    if (v[PosW] != v[PosW-1]) begin
      r = v[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

  // Saturate a 41-bit sum to the 40-bit signed range.
  function automatic logic signed [SumW-1:0] sat40(input logic signed [SumW:0] v);
    logic signed [SumW-1:0] r;
    if (v[SumW] != v[SumW-1]) begin
      r = v[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/plf_ctrl.sv
module plf_ctrl #(
  parameter int CORDIC_ITERATIONS = plf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output plf_pkg::dp_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE, S_RESTART, S_NOISE, S_MEAS, S_SUMP, S_MULD, S_MULI, S_STEER,
    S_CINIT, S_ROT, S_MOVEX, S_MOVEY, S_FIN, S_OUT
  } state_t;

  localparam logic [plf_pkg::IterW-1:0] LastIter = plf_pkg::IterW'(CORDIC_ITERATIONS - 1);

  state_t                      state_r, state_nxt;
  logic [plf_pkg::IterW-1:0]   iter_r, iter_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and the command for the current step.
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl.cmd      = plf_pkg::CMD_NONE;
    ctrl.iter     = iter_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.cmd  = plf_pkg::CMD_LOAD;
          state_nxt = in_operation ? S_RESTART : S_NOISE;
        end
      end
      S_RESTART: begin
        ctrl.cmd  = plf_pkg::CMD_RESTART;
        state_nxt = S_OUT;
      end
      S_NOISE: begin
        ctrl.cmd  = plf_pkg::CMD_NOISE;
        state_nxt = S_MEAS;
      end
      S_MEAS: begin
        ctrl.cmd  = plf_pkg::CMD_MEAS;
        state_nxt = S_SUMP;
      end
      S_SUMP: begin
        ctrl.cmd  = plf_pkg::CMD_SUMP;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        ctrl.cmd  = plf_pkg::CMD_MULD;
        state_nxt = S_MULI;
      end
      S_MULI: begin
        ctrl.cmd  = plf_pkg::CMD_MULI;
        state_nxt = S_STEER;
      end
      S_STEER: begin
        ctrl.cmd  = plf_pkg::CMD_STEER;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        ctrl.cmd  = plf_pkg::CMD_CINIT;
        iter_nxt  = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        ctrl.cmd = plf_pkg::CMD_ROT;
        if (iter_r == LastIter) begin
          state_nxt = S_MOVEX;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_MOVEX: begin
        ctrl.cmd  = plf_pkg::CMD_MOVEX;
        state_nxt = S_MOVEY;
      end
      S_MOVEY: begin
        ctrl.cmd  = plf_pkg::CMD_MOVEY;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctrl.cmd  = plf_pkg::CMD_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Wait until the result register is free, then load it.
        if (out_free) begin
          ctrl.cmd      = plf_pkg::CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/plf_datapath.sv
module plf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plf_pkg::dp_ctrl_t                   ctrl,
  input  logic signed [plf_pkg::SampW-1:0]    in_noise_sample,
  input  logic                                cfg_wr_en,
  input  logic [plf_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [plf_pkg::CfgDatW-1:0]         cfg_data,
  output logic signed [plf_pkg::PosW-1:0]     out_pos_x_out,
  output logic signed [plf_pkg::PosW-1:0]     out_pos_y_out,
  output logic signed [plf_pkg::AngW-1:0]     out_steering_angle,
  output logic signed [plf_pkg::PosW-1:0]     out_sensed_offset
);

  localparam int PosW = plf_pkg::PosW;
  localparam int SumW = plf_pkg::SumW;
  localparam int VecW = plf_pkg::VecW;
  localparam int ZW   = plf_pkg::ZW;

  // Configuration registers.
  logic [plf_pkg::GainW-1:0] gain_p_r, gain_d_r, gain_i_r;
  logic [plf_pkg::DistW-1:0] step_r, sigma_r;
  logic signed [PosW-1:0]    start_x_r, start_y_r;

  // Loop state.
  logic signed [PosW-1:0] pose_x_r, pose_y_r, last_r;
  logic signed [SumW-1:0] err_sum_r;

  // Working registers.
  logic signed [plf_pkg::SampW-1:0] sample_r;
  logic signed [41:0]               prod_n_r;
  logic signed [PosW-1:0]           meas_r;
  logic signed [49:0]               tp_r;
  logic signed [50:0]               td_r;
  logic signed [57:0]               ti_r;
  logic signed [plf_pkg::AngW-1:0]  steer_r;
  logic signed [VecW-1:0]           cx_r, cy_r;
  logic signed [ZW-1:0]             z_r;
  logic signed [59:0]               mv_r;

  // Result registers.
  logic signed [PosW-1:0]          ox_r, oy_r, om_r;
  logic signed [plf_pkg::AngW-1:0] os_r;

  logic signed [29:0]      noise_sh;
  logic signed [SumW-1:0]  sum_new;
  logic signed [32:0]      diff;
  logic signed [60:0]      t_neg;
  logic signed [42:0]      t_sh;
  logic signed [VecW-1:0]  dx, dy;
  logic signed [ZW-1:0]    atan_v;
  logic signed [29:0]      mv_sh;
  logic signed [25:0]      step_s;

  assign noise_sh = 30'(prod_n_r >>> 12);
  assign sum_new  = plf_pkg::sat40(41'(err_sum_r) + 41'(meas_r));
  assign diff     = 33'(meas_r) - 33'(last_r);
  assign t_neg    = -(61'(tp_r) + 61'(td_r) + 61'(ti_r));
  assign t_sh     = 43'(t_neg >>> 18);
  assign dx       = cy_r >>> ctrl.iter;
  assign dy       = cx_r >>> ctrl.iter;
  assign atan_v   = plf_pkg::atan_entry(ctrl.iter);
  assign mv_sh    = 30'(mv_r >>> 30);
  assign step_s   = $signed({1'b0, step_r});

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r  <= plf_pkg::GainPRst;
      gain_d_r  <= plf_pkg::GainDRst;
      gain_i_r  <= plf_pkg::GainIRst;
      step_r    <= plf_pkg::StepDistRst;
      sigma_r   <= plf_pkg::SigmaRst;
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        plf_pkg::REG_GAIN_P:  gain_p_r  <= cfg_data[plf_pkg::GainW-1:0];
        plf_pkg::REG_GAIN_D:  gain_d_r  <= cfg_data[plf_pkg::GainW-1:0];
        plf_pkg::REG_GAIN_I:  gain_i_r  <= cfg_data[plf_pkg::GainW-1:0];
        plf_pkg::REG_STEP:    step_r    <= cfg_data[plf_pkg::DistW-1:0];
        plf_pkg::REG_SIGMA:   sigma_r   <= cfg_data[plf_pkg::DistW-1:0];
        plf_pkg::REG_START_X: start_x_r <= $signed(cfg_data);
        plf_pkg::REG_START_Y: start_y_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Loop state: pose, previous measurement and error sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r  <= '0;
      pose_y_r  <= '0;
      last_r    <= '0;
      err_sum_r <= '0;
    end else begin
      case (ctrl.cmd)
        plf_pkg::CMD_RESTART: begin
          pose_x_r  <= start_x_r;
          pose_y_r  <= start_y_r;
          last_r    <= start_y_r;
          err_sum_r <= '0;
        end
        plf_pkg::CMD_SUMP:  err_sum_r <= sum_new;
        plf_pkg::CMD_MOVEY: pose_x_r <= plf_pkg::sat32(33'(pose_x_r) + 33'(mv_sh));
        plf_pkg::CMD_FIN: begin
          pose_y_r <= plf_pkg::sat32(33'(pose_y_r) + 33'(mv_sh));
          last_r   <= meas_r;
        end
        default: ;
      endcase
    end
  end

  // Sequenced arithmetic: one multiply or one rotation step per cycle.
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      plf_pkg::CMD_LOAD: sample_r <= in_noise_sample;
      plf_pkg::CMD_RESTART: begin
        meas_r  <= '0;
        steer_r <= '0;
      end
      plf_pkg::CMD_NOISE: prod_n_r <= $signed({1'b0, sigma_r}) * sample_r;
      plf_pkg::CMD_MEAS:  meas_r <= plf_pkg::sat32(33'(pose_y_r) + 33'(noise_sh));
      plf_pkg::CMD_SUMP:  tp_r <= $signed({1'b0, gain_p_r}) * meas_r;
      plf_pkg::CMD_MULD:  td_r <= $signed({1'b0, gain_d_r}) * diff;
      plf_pkg::CMD_MULI:  ti_r <= $signed({1'b0, gain_i_r}) * err_sum_r;
      plf_pkg::CMD_STEER: begin
        if (t_sh > 43'(plf_pkg::HalfPiQ14)) begin
          steer_r <= plf_pkg::HalfPiQ14;
        end else if (t_sh < -43'(plf_pkg::HalfPiQ14)) begin
          steer_r <= -plf_pkg::HalfPiQ14;
        end else begin
          steer_r <= t_sh[plf_pkg::AngW-1:0];
        end
      end
      plf_pkg::CMD_CINIT: begin
        cx_r <= plf_pkg::CordicK;
        cy_r <= '0;
        z_r  <= ZW'(steer_r) <<< 10;
      end
      plf_pkg::CMD_ROT: begin
        if (!z_r[ZW-1]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r  <= z_r - atan_v;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r  <= z_r + atan_v;
        end
      end
      plf_pkg::CMD_MOVEX: mv_r <= step_s * cx_r;
      plf_pkg::CMD_MOVEY: mv_r <= step_s * cy_r;
      plf_pkg::CMD_OUT: begin
        ox_r <= pose_x_r;
        oy_r <= pose_y_r;
        os_r <= steer_r;
        om_r <= meas_r;
      end
      default: ;
    endcase
  end

  assign out_pos_x_out      = ox_r;
  assign out_pos_y_out      = oy_r;
  assign out_steering_angle = os_r;
  assign out_sensed_offset  = om_r;

endmodule

// File: hw/rtl/pid_line_follow_sim_step_unit.sv
// One control tick of a line-following robot: a restart item loads the start pose, a step
// item senses y with noise, runs the PID law, clamps the heading to +-pi/2 and moves the
// pose along it using a CORDIC rotator. Items are handled one at a time. The time a step
// takes from transfer in to result ready is set mostly by the rotator, which does one
// iteration per cycle; a restart loads the start pose and then goes straight to the output.
// A finished result waits in an output register while the next item is taken in.
// Configuration writes must happen while the block is idle.
module pid_line_follow_sim_step_unit #(
  parameter int CORDIC_ITERATIONS = plf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic signed [plf_pkg::SampW-1:0]  in_noise_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [plf_pkg::PosW-1:0]   out_pos_x_out,
  output logic signed [plf_pkg::PosW-1:0]   out_pos_y_out,
  output logic signed [plf_pkg::AngW-1:0]   out_steering_angle,
  output logic signed [plf_pkg::PosW-1:0]   out_sensed_offset,
  input  logic                              cfg_wr_en,
  input  logic [plf_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [plf_pkg::CfgDatW-1:0]       cfg_data
);

  plf_pkg::dp_ctrl_t ctrl;

  plf_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_operation(in_operation),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ctrl        (ctrl)
  );

  plf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_noise_sample   (in_noise_sample),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_pos_x_out     (out_pos_x_out),
    .out_pos_y_out     (out_pos_y_out),
    .out_steering_angle(out_steering_angle),
    .out_sensed_offset (out_sensed_offset)
  );

endmodule

// File: hw/rtl/plf_checker.sv
module plf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [plf_pkg::AngW-1:0]  out_steering_angle
);

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // An accepted item keeps the input side busy on the next cycle.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transfer");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

  // The steering angle never exceeds a quarter turn.
  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_steering_angle <= plf_pkg::HalfPiQ14 &&
                   out_steering_angle >= -plf_pkg::HalfPiQ14))
    else $error("steering angle out of range");

endmodule

bind pid_line_follow_sim_step_unit plf_checker u_plf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_steering_angle(out_steering_angle)
);
